// ===== sv/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types, register indexes and constants of the TLV sample extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

    // Parser phases within one item
    typedef enum logic [1:0] {
        PH_ID_HI = 2'd0,
        PH_ID_LO = 2'd1,
        PH_LEN   = 2'd2,
        PH_DATA  = 2'd3
    } t_phase;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SLOT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_SLOT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_ID      = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [7:0]  RST_DECIM_PERIOD = 8'd20;
    localparam logic [7:0]  RST_ACCEL_SLOT   = 8'd0;
    localparam logic [7:0]  RST_QUAT_SLOT    = 8'd1;
    localparam logic [15:0] RST_ACCEL_ID     = 16'h4020;
    localparam logic [15:0] RST_QUAT_ID      = 16'h2010;

    // Channel numbering and group sizes
    localparam logic [2:0] CH_QUAT_BASE   = 3'd3;
    localparam logic [2:0] ACCEL_WORDS    = 3'd3;
    localparam logic [2:0] QUAT_WORDS     = 3'd4;
    localparam logic [2:0] ACCEL_LAST_IDX = 3'd2;
    localparam logic [2:0] QUAT_LAST_IDX  = 3'd3;
    localparam logic [2:0] WORD_IDX_MAX   = 3'd7;
    localparam logic [1:0] LAST_BYTE_POS  = 2'd3;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0]  decim_period;
        logic [7:0]  accel_slot;
        logic [7:0]  quat_slot;
        logic [15:0] accel_id;
        logic [15:0] quat_id;
    } t_cfg;

    // One result request handed from the parser to the output stage
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  channel;
        logic        last;
    } t_sample;

endpackage

// ===== sv/tse_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tse_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tse_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output tse_pkg::t_cfg                   o_cfg
);
    import tse_pkg::*;

    t_cfg r_cfg;

    // Load the addressed register, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decim_period <= RST_DECIM_PERIOD;
            r_cfg.accel_slot   <= RST_ACCEL_SLOT;
            r_cfg.quat_slot    <= RST_QUAT_SLOT;
            r_cfg.accel_id     <= RST_ACCEL_ID;
            r_cfg.quat_id      <= RST_QUAT_ID;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DECIM_PERIOD: r_cfg.decim_period <= i_cfg_wdata[7:0];
                CFG_ACCEL_SLOT:   r_cfg.accel_slot   <= i_cfg_wdata[7:0];
                CFG_QUAT_SLOT:    r_cfg.quat_slot    <= i_cfg_wdata[7:0];
                CFG_ACCEL_ID:     r_cfg.accel_id     <= i_cfg_wdata;
                CFG_QUAT_ID:      r_cfg.quat_id      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/tse_parser.sv =====
// ----------------------------------------------------------------------------
// tse_parser
// Item parser: tracks id, length and word assembly per accepted byte and
// raises a sample request when a selected word completes.
// ----------------------------------------------------------------------------
module tse_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    input  tse_pkg::t_cfg    i_cfg,
    output logic             o_sample_valid,
    output tse_pkg::t_sample o_sample
);
    import tse_pkg::*;

    t_phase      r_phase,       n_phase;
    logic [15:0] r_item_id,     n_item_id;
    logic [7:0]  r_bytes_left,  n_bytes_left;
    logic [31:0] r_word_shift,  n_word_shift;
    logic [1:0]  r_byte_pos,    n_byte_pos;
    logic [2:0]  r_word_idx,    n_word_idx;
    logic [7:0]  r_msg_count,   n_msg_count;

    logic [7:0]  bytes_dec;
    logic [31:0] word_next;
    logic        word_done;
    logic        item_done;
    logic        is_accel;
    logic        is_quat;
    logic [8:0]  count_inc;

    assign bytes_dec = r_bytes_left - 8'd1;
    assign word_next = {r_word_shift[23:0], i_byte};
    assign word_done = (r_phase == PH_DATA) && (r_byte_pos == LAST_BYTE_POS);
    assign item_done = (r_phase == PH_DATA) && (bytes_dec == 8'd0);
    assign is_accel  = (r_item_id == i_cfg.accel_id) && (r_msg_count == i_cfg.accel_slot);
    assign is_quat   = (r_item_id == i_cfg.quat_id) && (r_msg_count == i_cfg.quat_slot);
    assign count_inc = {1'b0, r_msg_count} + 9'd1;

    // Next phase: walk the item header, then payload; message end restarts
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_ID_HI: n_phase = PH_ID_LO;
            PH_ID_LO: n_phase = PH_LEN;
            PH_LEN:   n_phase = (i_byte == 8'd0) ? PH_ID_HI : PH_DATA;
            PH_DATA:  n_phase = item_done ? PH_ID_HI : PH_DATA;
            default:  n_phase = PH_ID_HI;
        endcase
        if (i_end) begin
            n_phase = PH_ID_HI;
        end
    end

    // Datapath updates and sample request
    always_comb begin
        n_item_id      = r_item_id;
        n_bytes_left   = r_bytes_left;
        n_word_shift   = r_word_shift;
        n_byte_pos     = r_byte_pos;
        n_word_idx     = r_word_idx;
        n_msg_count    = r_msg_count;
        o_sample_valid = 1'b0;
        o_sample.word    = word_next;
        o_sample.channel = r_word_idx;
        o_sample.last    = 1'b0;

        case (r_phase)
            PH_ID_HI: n_item_id = {i_byte, 8'd0};
            PH_ID_LO: n_item_id = {r_item_id[15:8], i_byte};
            PH_LEN: begin
                n_bytes_left = i_byte;
                n_word_shift = 32'd0;
                n_byte_pos   = 2'd0;
                n_word_idx   = 3'd0;
            end
            PH_DATA: begin
                n_bytes_left = bytes_dec;
                if (word_done) begin
                    // Emit accel first; quaternion only when accel does not match
                    if (is_accel && (r_word_idx < ACCEL_WORDS)) begin
                        o_sample_valid   = 1'b1;
                        o_sample.channel = r_word_idx;
                        o_sample.last    = (r_word_idx == ACCEL_LAST_IDX);
                    end else if (!is_accel && is_quat && (r_word_idx < QUAT_WORDS)) begin
                        o_sample_valid   = 1'b1;
                        o_sample.channel = CH_QUAT_BASE + r_word_idx;
                        o_sample.last    = (r_word_idx == QUAT_LAST_IDX);
                    end
                    if (r_word_idx < WORD_IDX_MAX) begin
                        n_word_idx = r_word_idx + 3'd1;
                    end
                    n_byte_pos   = 2'd0;
                    n_word_shift = 32'd0;
                end else begin
                    n_byte_pos   = r_byte_pos + 2'd1;
                    n_word_shift = word_next;
                end
            end
            default: begin
            end
        endcase

        // Drop per-item state at item or message end
        if (item_done || i_end) begin
            n_bytes_left = 8'd0;
            n_word_shift = 32'd0;
            n_byte_pos   = 2'd0;
            n_word_idx   = 3'd0;
        end
        // Advance the message counter modulo the period
        if (i_end) begin
            n_msg_count = (count_inc >= {1'b0, i_cfg.decim_period}) ? 8'd0 : count_inc[7:0];
        end
        if (!i_accept) begin
            o_sample_valid = 1'b0;
        end
    end

    // Hold state between accepted bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ID_HI;
            r_item_id    <= 16'd0;
            r_bytes_left <= 8'd0;
            r_word_shift <= 32'd0;
            r_byte_pos   <= 2'd0;
            r_word_idx   <= 3'd0;
            r_msg_count  <= 8'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_item_id    <= n_item_id;
            r_bytes_left <= n_bytes_left;
            r_word_shift <= n_word_shift;
            r_byte_pos   <= n_byte_pos;
            r_word_idx   <= n_word_idx;
            r_msg_count  <= n_msg_count;
        end
    end

endmodule

// ===== sv/tse_out_skid.sv =====
// ----------------------------------------------------------------------------
// tse_out_skid
// Output register with a skid entry, so the input side keeps a registered
// ready and never waits on the receiver combinationally.
// ----------------------------------------------------------------------------
module tse_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tse_pkg::t_sample i_sample,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output tse_pkg::t_sample o_sample
);
    import tse_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_sample r_main,       n_main;
    t_sample r_skid,       n_skid;

    // Refill the main register from skid first, else park the request in skid
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || i_ready) begin
            n_main_valid = r_skid_valid || i_push;
            n_main       = r_skid_valid ? r_skid : i_sample;
            n_skid_valid = 1'b0;
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_sample = r_main;

endmodule

// ===== sv/tlv_sample_extractor.sv =====
// ----------------------------------------------------------------------------
// tlv_sample_extractor
// Message payload parser that picks acceleration and quaternion words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one payload byte per request on i_s_tdata, i_s_tlast on
//   the last byte of a message. Master stream: one 32-bit sample per
//   request, o_m_tuser carries the channel (0..2 accel, 3..6 quaternion),
//   o_m_tlast marks the last word of a group.
//   Configuration: write i_cfg_wdata to register i_cfg_index while
//   i_cfg_we is high; the user must write only while the stream is idle,
//   the block does not enforce this. Throughput: one byte per cycle
//   while o_s_tready is high. A byte is parsed in the cycle it is
//   accepted; its sample goes to the main output register or the skid entry.
//   A two-entry output stage (register plus skid) keeps o_s_tready
//   registered; a stalled receiver still lets bytes in until one more
//   sample is parked in the skid entry, then o_s_tready drops until the
//   receiver takes a sample.
//   Reset (synchronous, active low) restores the register defaults, clears
//   the parser and message counter and empties the output stage.
// ----------------------------------------------------------------------------
module tlv_sample_extractor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] payload_byte
    input  logic                            i_s_tlast,   // message_end
    // Master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // [31:0] sample_word
    output logic [2:0]                      o_m_tuser,   // [2:0] channel
    output logic                            o_m_tlast,   // group_last
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import tse_pkg::*;

    t_cfg    cfg;
    t_sample parse_sample;
    t_sample out_sample;
    logic    parse_valid;
    logic    space;
    logic    in_accept;

    assign o_s_tready = space;
    assign in_accept  = i_s_tvalid && space;

    tse_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tse_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_byte         (i_s_tdata),
        .i_end          (i_s_tlast),
        .i_cfg          (cfg),
        .o_sample_valid (parse_valid),
        .o_sample       (parse_sample)
    );

    tse_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (parse_valid),
        .i_sample (parse_sample),
        .o_space  (space),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_sample (out_sample)
    );

    assign o_m_tdata = out_sample.word;
    assign o_m_tuser = out_sample.channel;
    assign o_m_tlast = out_sample.last;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TLV sample extractor.
// ----------------------------------------------------------------------------
// Payload bytes are queued as whole messages of TLV items, mostly well formed
// with random content, some truncated, some plain noise. A clocked driver
// presents them on the slave stream and a built-in parser model forecasts
// the samples for each accepted byte. A clocked monitor takes samples off the
// master stream and compares channel, word and group flag with the oldest
// forecast. Both sides idle in random bursts. Between phases the bench
// drains the block and writes a fresh register setting.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tse_pkg::*;

    // One slave-side request: payload byte and message end flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_req;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = '0;
    logic                  i_s_tlast   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [31:0]           o_m_tdata;
    logic [2:0]            o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    tlv_sample_extractor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Byte stream waiting for the driver, samples waiting for the monitor
    t_payload_req payload_pending[$];
    t_sample      samples_due[$];

    int unsigned n_fail    = 0;
    int unsigned n_bytes   = 0;
    int unsigned n_samples = 0;

    // Idle control for both streams
    bit          calm    = 1'b0;
    int unsigned src_pct = 0;
    int unsigned snk_pct = 0;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;

    // Parser model: register copy and per-item state
    t_cfg        cfg_m = '{decim_period: RST_DECIM_PERIOD, accel_slot: RST_ACCEL_SLOT,
                           quat_slot: RST_QUAT_SLOT, accel_id: RST_ACCEL_ID,
                           quat_id: RST_QUAT_ID};
    t_phase      prs_phase = PH_ID_HI;
    logic [15:0] prs_id    = '0;
    logic [7:0]  prs_left  = '0;
    logic [31:0] prs_shift = '0;
    logic [1:0]  prs_pos   = '0;
    logic [2:0]  prs_word  = '0;
    logic [7:0]  msg_count = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop back to the id phase and forget the current item
    task automatic clear_item();
        prs_phase = PH_ID_HI;
        prs_left  = '0;
        prs_shift = '0;
        prs_pos   = '0;
        prs_word  = '0;
    endtask

    // Advance the parser model by one byte and queue any sample it yields
    task automatic parse_payload_byte(input logic [7:0] b, input logic last);
        t_sample     s;
        logic        acc;
        logic        qua;
        int unsigned nxt;
        case (prs_phase)
            PH_ID_HI: begin
                prs_id    = {b, 8'h00};
                prs_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                prs_id[7:0] = b;
                prs_phase   = PH_LEN;
            end
            PH_LEN: begin
                prs_left  = b;
                prs_shift = '0;
                prs_pos   = '0;
                prs_word  = '0;
                prs_phase = (b == 8'd0) ? PH_ID_HI : PH_DATA;
            end
            PH_DATA: begin
                prs_shift = {prs_shift[23:0], b};
                if (prs_pos == LAST_BYTE_POS) begin
                    acc = (prs_id == cfg_m.accel_id) && (msg_count == cfg_m.accel_slot);
                    qua = (prs_id == cfg_m.quat_id) && (msg_count == cfg_m.quat_slot);
                    if (acc && prs_word < ACCEL_WORDS) begin
                        s.word    = prs_shift;
                        s.channel = prs_word;
                        s.last    = (prs_word == ACCEL_LAST_IDX);
                        samples_due.push_back(s);
                        n_samples++;
                    end else if (!acc && qua && prs_word < QUAT_WORDS) begin
                        s.word    = prs_shift;
                        s.channel = CH_QUAT_BASE + prs_word;
                        s.last    = (prs_word == QUAT_LAST_IDX);
                        samples_due.push_back(s);
                        n_samples++;
                    end
                    if (prs_word < WORD_IDX_MAX)
                        prs_word++;
                    prs_pos   = '0;
                    prs_shift = '0;
                end else begin
                    prs_pos++;
                end
                prs_left--;
                if (prs_left == 8'd0)
                    clear_item();
            end
            default: begin
                clear_item();
            end
        endcase
        // Message end: step the decimation counter and restart parsing
        if (last) begin
            nxt       = msg_count + 1;
            msg_count = (nxt >= cfg_m.decim_period) ? 8'd0 : nxt[7:0];
            clear_item();
        end
    endtask

    // Slave-side driver: present queued bytes, idle in bursts
    always @(posedge i_clk) begin
        t_payload_req req;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                parse_payload_byte(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (!calm && payload_pending.size() != 0 &&
                             $urandom_range(0, 99) < src_pct) begin
                    src_gap = $urandom_range(0, 8);
                    i_s_tvalid <= 1'b0;
                end else if (payload_pending.size() != 0) begin
                    req = payload_pending.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= req.data;
                    i_s_tlast  <= req.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side monitor: check each sample, stall in bursts
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: unexpected sample expected none actual word %h ch %0d last %b",
                             $time, o_m_tdata, o_m_tuser, o_m_tlast);
                    n_fail++;
                end else begin
                    want = samples_due.pop_front();
                    if (o_m_tdata !== want.word) begin
                        $display("%0t: sample word expected %h actual %h",
                                 $time, want.word, o_m_tdata);
                        n_fail++;
                    end
                    if (o_m_tuser !== want.channel) begin
                        $display("%0t: channel expected %0d actual %0d",
                                 $time, want.channel, o_m_tuser);
                        n_fail++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $display("%0t: group last expected %b actual %b",
                                 $time, want.last, o_m_tlast);
                        n_fail++;
                    end
                end
            end
            if (snk_gap != 0) begin
                snk_gap--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < snk_pct) begin
                snk_gap = $urandom_range(0, 8);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic last);
        t_payload_req req;
        req.data = data;
        req.last = last;
        payload_pending.push_back(req);
        n_bytes++;
    endtask

    // Queue one message: mostly TLV items aimed at the selected ids
    task automatic queue_message();
        logic [7:0]  msg[$];
        logic [15:0] id;
        int unsigned n_items;
        int unsigned len;
        int unsigned cut;
        int unsigned sel;
        if ($urandom_range(0, 99) < 15) begin
            // Noise: a few random bytes, stray message ends
            n_items = $urandom_range(1, 8);
            for (int i = 0; i < n_items; i++)
                push_byte(8'($urandom), (i == n_items - 1) || ($urandom_range(0, 7) == 0));
        end else begin
            n_items = $urandom_range(1, 4);
            for (int k = 0; k < n_items; k++) begin
                sel = $urandom_range(0, 9);
                id  = (sel < 4) ? cfg_m.accel_id : (sel < 8) ? cfg_m.quat_id : 16'($urandom);
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    1:       len = $urandom_range(1, 11);
                    2, 3:    len = 12;
                    4, 5:    len = 16;
                    6:       len = $urandom_range(17, 40);
                    7:       len = $urandom_range(13, 15);
                    8:       len = ($urandom_range(0, 9) != 0) ? $urandom_range(2, 8) :
                                   $urandom_range(0, 1) ? 255 : $urandom_range(41, 254);
                    default: len = $urandom_range(20, 28);
                endcase
                msg.push_back(id[15:8]);
                msg.push_back(id[7:0]);
                msg.push_back(8'(len));
                for (int j = 0; j < len; j++)
                    msg.push_back(8'($urandom));
            end
            // Truncate now and then, anywhere in a header or payload
            if (msg.size() > 1 && $urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, msg.size() - 1);
                while (msg.size() > cut)
                    void'(msg.pop_back());
            end
            foreach (msg[i])
                push_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    // Queue messages for one phase, with fresh idle rates
    task automatic queue_traffic(input int unsigned target);
        int unsigned start;
        start = n_bytes;
        if (!calm) begin
            src_pct = 10 * $urandom_range(0, 4);
            snk_pct = 10 * $urandom_range(0, 4);
        end
        while (n_bytes - start < target)
            queue_message();
    endtask

    // Wait until every byte is taken and every sample has come out
    task automatic drain();
        while (payload_pending.size() != 0 || i_s_tvalid || samples_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_DECIM_PERIOD: cfg_m.decim_period = value[7:0];
            CFG_ACCEL_SLOT:   cfg_m.accel_slot   = value[7:0];
            CFG_QUAT_SLOT:    cfg_m.quat_slot    = value[7:0];
            CFG_ACCEL_ID:     cfg_m.accel_id     = value;
            CFG_QUAT_ID:      cfg_m.quat_id      = value;
            default: ;
        endcase
    endtask

    // Drain, then write the full register set; upper bits of byte registers junk
    task automatic apply_cfg(input logic [7:0] period, input logic [7:0] aslot,
                             input logic [7:0] qslot, input logic [15:0] aid,
                             input logic [15:0] qid);
        drain();
        write_reg(CFG_DECIM_PERIOD, {8'($urandom), period});
        write_reg(CFG_ACCEL_SLOT,   {8'($urandom), aslot});
        write_reg(CFG_QUAT_SLOT,    {8'($urandom), qslot});
        write_reg(CFG_ACCEL_ID,     aid);
        write_reg(CFG_QUAT_ID,      qid);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Main sequence
    initial begin
        logic [15:0] aid;
        int unsigned n_phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_pct = 20;
        snk_pct = 20;

        // Full acceleration item with extreme bytes, counter at accel slot
        push_byte(8'h40, 1'b0); push_byte(8'h20, 1'b0); push_byte(8'h0C, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0); push_byte(8'hFE, 1'b1);
        // Zero length item, then a quaternion item cut short by message end
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h20, 1'b0); push_byte(8'h10, 1'b0); push_byte(8'h08, 1'b0);
        push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0); push_byte(8'h78, 1'b0); push_byte(8'h9A, 1'b1);
        queue_traffic(120);

        // Fixed settings: extremes, equal ids, zero period, unreachable slots
        apply_cfg(8'd2,   8'd0,   8'd1, RST_ACCEL_ID, RST_QUAT_ID);
        queue_traffic(150);
        apply_cfg(8'd1,   8'd0,   8'd0, 16'h1234, 16'h1234);
        queue_traffic(150);
        apply_cfg(8'd3,   8'd2,   8'd2, 16'h0000, 16'hFFFF);
        queue_traffic(150);
        apply_cfg(8'd0,   8'd0,   8'd5, 16'hFFFF, 16'h0000);
        queue_traffic(120);
        apply_cfg(8'd255, 8'd254, 8'd0, 16'hA5A5, 16'h5A5A);
        queue_traffic(100);
        apply_cfg(8'd4,   8'd1,   8'd3, 16'($urandom), 16'($urandom));
        queue_traffic(120);

        // Random settings until enough bytes and samples have gone through
        n_phase = 0;
        while ((n_bytes < 1300 || n_samples < 60) && n_phase < 40) begin
            aid = 16'($urandom);
            apply_cfg(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                      8'($urandom_range(0, 6)), aid,
                      ($urandom_range(0, 3) == 0) ? aid : 16'($urandom));
            queue_traffic(150);
            n_phase++;
        end

        // Closing stretch at full rate
        drain();
        calm    = 1'b1;
        src_pct = 0;
        snk_pct = 0;
        queue_traffic(100);

        drain();
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop
    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tse_pkg.sv
sv/tse_cfg_regs.sv
sv/tse_parser.sv
sv/tse_out_skid.sv
sv/tlv_sample_extractor.sv
sim/tb_top.sv
